// ----- rtl/id3x_pkg.sv -----
// ============================================================================
// id3x_pkg
// Shared types and constants of the ID3v2 tag text extractor.
// ============================================================================
package id3x_pkg;

	// Default sizes of the parse window and of one text field.
	localparam int DEF_WINDOW_BYTES = 4096;
	localparam int DEF_FIELD_LEN    = 32;

	// Field kind codes of a result word.
	localparam logic [1:0] KIND_TITLE   = 2'd0;
	localparam logic [1:0] KIND_ARTIST  = 2'd1;
	localparam logic [1:0] KIND_ALBUM   = 2'd2;
	localparam logic [1:0] KIND_SUMMARY = 2'd3;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	// Identifier patterns, ASCII big-endian.
	localparam logic [23:0] ID_ID3  = 24'h494433;
	localparam logic [23:0] ID_TT2  = 24'h545432;
	localparam logic [31:0] ID_TIT2 = 32'h54495432;
	localparam logic [23:0] ID_TP1  = 24'h545031;
	localparam logic [31:0] ID_TPE1 = 32'h54504531;
	localparam logic [23:0] ID_TAL  = 24'h54414C;

	// Frame header sizes for new and old tag versions.
	localparam logic [3:0] HDR_V3 = 4'd10;
	localparam logic [3:0] HDR_V2 = 4'd6;
	localparam logic [7:0] VER_V3 = 8'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  field_kind;
		logic [4:0]  char_pos;
		logic [7:0]  char_value;
		logic        found_tag;
		logic [28:0] audio_start;
		logic        last_result;
	} out_item_t;

	// Words handed from the parser to the result queue in one cycle.
	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  item0;
		out_item_t  item1;
	} push_t;

endpackage

// ----- rtl/id3x_front.sv -----
// ============================================================================
// id3x_front
// Byte parser: tracks the header and frame walk and builds result words.
// ============================================================================
module id3x_front #(
	parameter int WINDOW_BYTES = id3x_pkg::DEF_WINDOW_BYTES,
	parameter int FIELD_LEN    = id3x_pkg::DEF_FIELD_LEN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  id3x_pkg::in_item_t item,
	output id3x_pkg::push_t    push
);
	import id3x_pkg::*;

	localparam int OW  = $clog2(WINDOW_BYTES + 1);
	localparam int CW0 = $clog2(FIELD_LEN);
	localparam int CW  = (CW0 < 1) ? 1 : CW0;
	localparam int PW  = (CW < 5) ? 5 : CW;
	localparam logic [31:0] CNT_MAX = 32'(FIELD_LEN - 1);

	logic [OW-1:0] off_q, c_off, n_off;
	logic [7:0]    ver_q, c_ver, n_ver;
	logic [28:0]   tl_q, c_tl, n_tl;
	logic [31:0]   nfo_q, c_nfo, n_nfo;
	logic [31:0]   fid_q, c_fid, n_fid;
	logic [31:0]   fl_q, c_fl, n_fl;
	logic [1:0]    kind_q, c_kind, n_kind;
	logic [CW-1:0] rem_q, c_rem, n_rem;
	logic [PW-1:0] pos_q, c_pos, n_pos;
	logic [31:0]   cs_q, c_cs, n_cs;
	logic          nul_q, c_nul, n_nul;
	logic          tv_q, c_tv, n_tv;
	logic          done_q, c_done, n_done;
	logic          hact_q, c_hact, n_hact;

	// Restart on the first byte of a file, then the per-byte update.
	always_comb begin
		logic [31:0] off32;
		logic [3:0]  rel;
		logic        hact;
		logic        v3;
		logic [31:0] fid_b;
		logic [31:0] fl_b;
		logic [1:0]  fk;
		logic [31:0] cnt;
		logic [32:0] nxt;
		logic [3:0]  hdr;
		logic        ch;
		logic [7:0]  cv;
		out_item_t   chr;
		out_item_t   sum;

		if (item.first_byte) begin
			c_off = '0; c_ver = '0; c_tl = '0; c_nfo = 32'd10; c_fid = '0; c_fl = '0;
			c_kind = KIND_NONE; c_rem = '0; c_pos = '0; c_cs = '0; c_nul = 1'b0;
			c_tv = 1'b0; c_done = 1'b0; c_hact = 1'b0;
		end else begin
			c_off = off_q; c_ver = ver_q; c_tl = tl_q; c_nfo = nfo_q; c_fid = fid_q;
			c_fl = fl_q; c_kind = kind_q; c_rem = rem_q; c_pos = pos_q; c_cs = cs_q;
			c_nul = nul_q; c_tv = tv_q; c_done = done_q; c_hact = hact_q;
		end
		n_off = c_off; n_ver = c_ver; n_tl = c_tl; n_nfo = c_nfo; n_fid = c_fid;
		n_fl = c_fl; n_kind = c_kind; n_rem = c_rem; n_pos = c_pos; n_cs = c_cs;
		n_nul = c_nul; n_tv = c_tv; n_done = c_done; n_hact = c_hact;

		off32 = {{(32 - OW){1'b0}}, c_off};
		v3    = (c_ver >= VER_V3);
		hdr   = v3 ? HDR_V3 : HDR_V2;
		rel   = 4'(off32 - c_nfo);
		hact  = c_hact;
		fid_b = c_fid;
		fl_b  = c_fl;
		fk    = KIND_NONE;
		cnt   = '0;
		nxt   = '0;
		ch    = 1'b0;
		cv    = item.data_byte;

		if (!c_done && (c_off < OW'(WINDOW_BYTES))) begin
			if (c_off < OW'(3)) begin
				n_fid = {8'h00, c_fid[15:0], item.data_byte};
				if (c_off == OW'(2)) begin
					n_tv = ({c_fid[15:0], item.data_byte} == ID_ID3);
				end
			end else if (c_off == OW'(3)) begin
				n_ver = item.data_byte;
			end else if ((c_off >= OW'(6)) && (c_off <= OW'(9))) begin
				case (c_off[1:0])
					2'd2:    n_tl = c_tl | {item.data_byte, 21'd0};
					2'd3:    n_tl = c_tl | {7'd0, item.data_byte, 14'd0};
					2'd0:    n_tl = c_tl | {14'd0, item.data_byte, 7'd0};
					default: n_tl = c_tl | {21'd0, item.data_byte};
				endcase
			end else if ((c_off >= OW'(10)) && c_tv) begin
				// Character copy, or the start of the next frame header.
				if ((c_kind != KIND_NONE) && (off32 >= c_cs)) begin
					ch = 1'b1;
					if (c_nul) begin
						cv = 8'h00;
					end else if (item.data_byte == 8'h00) begin
						n_nul = 1'b1;
					end
					n_pos = c_pos + PW'(1);
					n_rem = c_rem - CW'(1);
					if (c_rem == CW'(1)) begin
						n_kind = KIND_NONE;
					end
				end else if (!c_hact && (off32 == c_nfo) && (off32 < {3'd0, c_tl})) begin
					hact  = 1'b1;
					fid_b = '0;
					fl_b  = '0;
				end
				n_hact = hact;
				if (hact) begin
					n_fid = fid_b;
					n_fl  = fl_b;
					if (rel < 4'd4) begin
						n_fid = {fid_b[23:0], item.data_byte};
					end
					if (v3 ? ((rel >= 4'd4) && (rel <= 4'd7)) : ((rel >= 4'd3) && (rel <= 4'd5))) begin
						n_fl = {fl_b[23:0], item.data_byte};
					end
					if (rel == (v3 ? 4'd9 : 4'd5)) begin
						// Frame header complete: classify and plan the copy.
						if ((n_fid[31:8] == ID_TT2) || (n_fid == ID_TIT2)) begin
							fk = KIND_TITLE;
						end else if ((n_fid[31:8] == ID_TP1) || (n_fid == ID_TPE1)) begin
							fk = KIND_ARTIST;
						end else if (n_fid[31:8] == ID_TAL) begin
							fk = KIND_ALBUM;
						end
						cnt = (n_fl == 32'd0) ? 32'd0 : (n_fl - 32'd1);
						if (cnt > CNT_MAX) begin
							cnt = CNT_MAX;
						end
						if ((fk != KIND_NONE) && (cnt != 32'd0)) begin
							n_kind = fk;
							n_rem  = cnt[CW-1:0];
							n_pos  = '0;
							n_nul  = 1'b0;
							n_cs   = c_nfo + {28'd0, hdr} + 32'd1;
						end
						nxt    = {1'b0, c_nfo} + {29'd0, hdr} + {1'b0, n_fl};
						n_nfo  = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
						n_hact = 1'b0;
					end
				end
			end
			n_off = c_off + OW'(1);
		end

		chr.field_kind  = c_kind;
		chr.char_pos    = c_pos[4:0];
		chr.char_value  = cv;
		chr.found_tag   = 1'b0;
		chr.audio_start = '0;
		chr.last_result = 1'b0;

		sum.field_kind  = KIND_SUMMARY;
		sum.char_pos    = '0;
		sum.char_value  = '0;
		sum.found_tag   = n_tv;
		sum.audio_start = n_tv ? n_tl : 29'd0;
		sum.last_result = 1'b1;

		push.item0 = ch ? chr : sum;
		push.item1 = sum;
		push.cnt   = '0;
		if (fire && !c_done) begin
			push.cnt = {1'b0, ch} + {1'b0, item.end_of_data};
		end
		if (!c_done && item.end_of_data) begin
			n_done = 1'b1;
		end
	end

	// Parse state, updated once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0; ver_q <= '0; tl_q <= '0; nfo_q <= 32'd10; fid_q <= '0;
			fl_q <= '0; kind_q <= KIND_NONE; rem_q <= '0; pos_q <= '0; cs_q <= '0;
			nul_q <= 1'b0; tv_q <= 1'b0; done_q <= 1'b0; hact_q <= 1'b0;
		end else if (fire) begin
			off_q <= n_off; ver_q <= n_ver; tl_q <= n_tl; nfo_q <= n_nfo; fid_q <= n_fid;
			fl_q <= n_fl; kind_q <= n_kind; rem_q <= n_rem; pos_q <= n_pos; cs_q <= n_cs;
			nul_q <= n_nul; tv_q <= n_tv; done_q <= n_done; hact_q <= n_hact;
		end
	end

endmodule

// ----- rtl/id3x_queue.sv -----
// ============================================================================
// id3x_queue
// Four-entry result queue taking up to two words a cycle, giving one when not stalled.
// ============================================================================
module id3x_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  id3x_pkg::push_t     push,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output id3x_pkg::out_item_t out_data
);
	import id3x_pkg::*;

	out_item_t  mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;
	logic       pop;

	// Room for two words is needed before a byte is taken.
	assign full      = (count_q > 3'd2);
	assign out_valid = (count_q != 3'd0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;

	// Storage.
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.item0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_q + 2'd1] <= push.item1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push.cnt;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push.cnt} - {2'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4) else $error("queue count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> !full) else $error("push into full queue");
	a_pair_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2) |-> (push.item1.last_result && !push.item0.last_result))
		else $error("word pair must end with the summary");
	a_cnt_legal: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd3) else $error("too many words pushed");
`endif

endmodule

// ----- rtl/id3v2_tag_text_extractor_unit.sv -----
// ============================================================================
// id3v2_tag_text_extractor_unit
// Parses an ID3v2 header from a byte stream and emits title, artist, album
// characters and one summary word per file that is closed by end_of_data.
// ============================================================================
// Each result word is built combinationally from its byte and is written into the queue as the byte is accepted.
// Throughput: one byte per cycle; a byte gives at most two words and the
// output drains one word per cycle while out_stall is low, through a four-entry
// queue, so input stalls only while the queue holds more than two words.
// Reset: arst_n clears the parse state and empties the queue at once.
module id3v2_tag_text_extractor_unit #(
	parameter int WINDOW_BYTES = id3x_pkg::DEF_WINDOW_BYTES,
	parameter int FIELD_LEN    = id3x_pkg::DEF_FIELD_LEN
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  id3x_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output id3x_pkg::out_item_t out_data
);
	import id3x_pkg::*;

	push_t push;
	logic  full;
	logic  fire;

	assign in_stall = full;
	assign fire     = in_valid && !full;

	id3x_front #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.FIELD_LEN   (FIELD_LEN)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (in_data),
		.push  (push)
	);

	id3x_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ----- tb/tb_id3v2_tag_text_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the ID3v2 tag text extractor
// Feeds audio file openings byte by byte: hand-built tags first, then random
// tags, broken tags and noise under varying idle and stall patterns. A local
// model of the parser predicts each title, artist, album and summary word,
// and a checker compares every delivered word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_id3v2_tag_text_extractor_unit;
	import id3x_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN  = DEF_WINDOW_BYTES;
	localparam int FLEN = DEF_FIELD_LEN;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	id3v2_tag_text_extractor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #10 clk = ~clk;

	// Parser state of the local model.
	logic [12:0] p_ofs;
	logic [7:0]  p_ver;
	logic [31:0] p_tlen, p_next, p_id, p_flen, p_cstart;
	logic [1:0]  p_ckind;
	logic [4:0]  p_crem, p_cpos;
	bit          p_nul, p_tvalid, p_done, p_hdr;

	out_item_t   words_due[$];
	logic [7:0]  file_q[$];
	int          bytes_sent = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_left = 0;
	bit          failed = 1'b0;

	task automatic parser_clear();
		p_ofs = '0; p_ver = '0; p_tlen = '0; p_next = 32'd10; p_id = '0; p_flen = '0;
		p_ckind = KIND_NONE; p_crem = '0; p_cpos = '0; p_nul = 0; p_tvalid = 0;
		p_done = 0; p_hdr = 0; p_cstart = '0;
	endtask

	// Decode a completed frame header and arm the text copy if it matches.
	task automatic frame_header_done();
		logic [31:0] hsz, cnt;
		logic [1:0]  kind;
		logic [32:0] nxt;
		hsz = (p_ver >= VER_V3) ? 32'(HDR_V3) : 32'(HDR_V2);
		kind = KIND_NONE;
		if (p_id[31:8] == ID_TT2 || p_id == ID_TIT2)
			kind = KIND_TITLE;
		else if (p_id[31:8] == ID_TP1 || p_id == ID_TPE1)
			kind = KIND_ARTIST;
		else if (p_id[31:8] == ID_TAL)
			kind = KIND_ALBUM;
		cnt = (p_flen == 0) ? 32'd0 : p_flen - 1;
		if (cnt > FLEN - 1)
			cnt = FLEN - 1;
		if (kind != KIND_NONE && cnt > 0) begin
			p_ckind = kind;
			p_crem = cnt[4:0];
			p_cpos = '0;
			p_nul = 0;
			p_cstart = p_next + hsz + 1;
		end
		nxt = {1'b0, p_next} + hsz + p_flen;
		p_next = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
		p_hdr = 0;
	endtask

	// Advance the model by one accepted byte and queue the words it causes.
	task automatic parse_byte(input in_item_t it);
		logic [31:0] off, lim, rel;
		logic [7:0]  v;
		bit          v3;
		out_item_t   w;
		if (it.first_byte)
			parser_clear();
		if (p_done)
			return;
		off = 32'(p_ofs);
		if (off < WIN) begin
			if (off < 3) begin
				p_id = ((p_id << 8) | it.data_byte) & 32'hFF_FFFF;
				if (off == 2)
					p_tvalid = (p_id[23:0] == ID_ID3);
			end else if (off == 3) begin
				p_ver = it.data_byte;
			end else if (off >= 6 && off <= 9) begin
				p_tlen |= 32'(it.data_byte) << (7 * (9 - off));
			end else if (off >= 10 && p_tvalid) begin
				lim = (p_tlen < WIN) ? p_tlen : WIN;
				if (p_ckind != KIND_NONE && off >= p_cstart) begin
					v = it.data_byte;
					if (p_nul)
						v = '0;
					else if (it.data_byte == 0)
						p_nul = 1;
					w = '0;
					w.field_kind = p_ckind;
					w.char_pos = p_cpos;
					w.char_value = v;
					words_due.push_back(w);
					p_cpos++;
					p_crem--;
					if (p_crem == 0)
						p_ckind = KIND_NONE;
				end else if (!p_hdr && off == p_next && off < lim) begin
					p_hdr = 1;
					p_id = '0;
					p_flen = '0;
				end
				if (p_hdr) begin
					rel = off - p_next;
					v3 = p_ver >= VER_V3;
					if (rel < 4)
						p_id = (p_id << 8) | it.data_byte;
					if (v3 ? (rel >= 4 && rel <= 7) : (rel >= 3 && rel <= 5))
						p_flen = (p_flen << 8) | it.data_byte;
					if (rel == (v3 ? 9 : 5))
						frame_header_done();
				end
			end
			p_ofs = p_ofs + 13'd1;
		end
		if (it.end_of_data) begin
			w = '0;
			w.field_kind = KIND_SUMMARY;
			w.found_tag = p_tvalid;
			w.audio_start = p_tvalid ? p_tlen[28:0] : '0;
			w.last_result = 1'b1;
			words_due.push_back(w);
			p_done = 1;
		end
	endtask

	// Offer one byte, idling first at random, and predict once it is taken.
	task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
		in_item_t it;
		it.data_byte = b;
		it.first_byte = first;
		it.end_of_data = last;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do
			@(posedge clk);
		while (in_stall);
		parse_byte(it);
		bytes_sent++;
	endtask

	// Receiver: forced hold-off when requested, otherwise random stalls.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Compare each delivered word with the oldest prediction.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (words_due.size() == 0) begin
				$error("unexpected word %p", out_data);
				failed = 1'b1;
			end else begin
				e = words_due.pop_front();
				if (out_data.field_kind !== e.field_kind) begin
					$error("field_kind exp %0d got %0d", e.field_kind, out_data.field_kind);
					failed = 1'b1;
				end
				if (out_data.char_pos !== e.char_pos) begin
					$error("char_pos exp %0d got %0d", e.char_pos, out_data.char_pos);
					failed = 1'b1;
				end
				if (out_data.char_value !== e.char_value) begin
					$error("char_value exp %0h got %0h", e.char_value, out_data.char_value);
					failed = 1'b1;
				end
				if (out_data.found_tag !== e.found_tag) begin
					$error("found_tag exp %0d got %0d", e.found_tag, out_data.found_tag);
					failed = 1'b1;
				end
				if (out_data.audio_start !== e.audio_start) begin
					$error("audio_start exp %0h got %0h", e.audio_start,
						out_data.audio_start);
					failed = 1'b1;
				end
				if (out_data.last_result !== e.last_result) begin
					$error("last_result exp %0d got %0d", e.last_result,
						out_data.last_result);
					failed = 1'b1;
				end
			end
		end
	end

	// Append one frame: id, size, flags on new versions, then body bytes.
	task automatic put_frame(input bit v3, input logic [31:0] id, input logic [31:0] size,
			input int body_n);
		for (int i = 0; i < (v3 ? 4 : 3); i++)
			file_q.push_back(id[31 - 8 * i -: 8]);
		for (int i = (v3 ? 3 : 2); i >= 0; i--)
			file_q.push_back(size[8 * i +: 8]);
		if (v3) begin
			file_q.push_back(8'($urandom_range(255)));
			file_q.push_back(8'($urandom_range(255)));
		end
		for (int i = 0; i < body_n; i++)
			file_q.push_back(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(32, 126)));
	endtask

	// Header for a tag of the given size, with syncsafe bytes unless raw.
	task automatic put_header(input logic [7:0] ver, input logic [31:0] tsz, input bit raw);
		file_q.delete();
		file_q.push_back("I"); file_q.push_back("D"); file_q.push_back("3");
		file_q.push_back(ver);
		file_q.push_back(8'($urandom_range(255)));
		file_q.push_back(8'($urandom_range(255)));
		for (int i = 3; i >= 0; i--)
			file_q.push_back(raw ? 8'($urandom_range(255)) : {1'b0, tsz[7 * i +: 7]});
	endtask

	function automatic logic [31:0] pick_id();
		case ($urandom_range(7))
			0: return {ID_TT2, 8'($urandom_range(255))};
			1: return ID_TIT2;
			2: return {ID_TP1, 8'h20};
			3: return ID_TPE1;
			4: return {ID_TAL, 8'h42};
			5: return {ID_TAL, 8'($urandom_range(255))};
			6: return {ID_TIT2[31:8], 8'h33};
			default: return $urandom;
		endcase
	endfunction

	// Random tag of nfr frames; unless raw, the tag size is patched in at the end.
	task automatic build_tag(input logic [7:0] ver, input int nfr, input bit raw);
		bit          v3;
		int          n;
		logic [31:0] sz, tsz;
		v3 = ver >= VER_V3;
		put_header(ver, 0, raw);
		for (int f = 0; f < nfr; f++) begin
			n = $urandom_range(0, 40);
			sz = n;
			if ($urandom_range(19) == 0)
				sz = $urandom | 32'hF000_0000;
			if (!v3)
				sz &= 32'h00FF_FFFF;
			put_frame(v3, pick_id(), sz, n);
		end
		tsz = file_q.size() - 10 + $urandom_range(0, 8) - ($urandom_range(3) == 0 ? 6 : 0);
		if (!raw)
			for (int i = 0; i < 4; i++)
				file_q[6 + i] = {1'b0, tsz[7 * (3 - i) +: 7]};
		repeat ($urandom_range(0, 6))
			file_q.push_back(8'($urandom_range(255)));
	endtask

	// Send the file in file_q, optionally ending it, then a few stray bytes.
	task automatic send_file(input bit ends, input int strays);
		for (int i = 0; i < file_q.size(); i++)
			send_byte(file_q[i], i == 0, ends && i == file_q.size() - 1);
		repeat (strays)
			send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
	endtask

	// Hand-built files: no tag, single byte, clipped and empty frames.
	task automatic test_directed();
		file_q = '{8'h49, 8'h44, 8'h34, 8'hFF};
		send_file(1, 0);
		send_byte(8'hFF, 1'b1, 1'b1);
		send_byte(8'h00, 1'b0, 1'b1);
		put_header(8'd3, 32'd40, 0);
		put_frame(1, ID_TIT2, 32'd1, 1);
		put_frame(1, ID_TPE1, 32'd0, 0);
		put_frame(1, {ID_TAL, 8'h42}, 32'd45, 3);
		send_file(1, 0);
		// Old version tag with a title cut short by a restart.
		put_header(8'd2, 32'd30, 0);
		put_frame(0, {ID_TT2, 8'h00}, 32'd4, 2);
		send_file(0, 0);
		file_q = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00, 8'h7F, 8'h7F};
		send_file(1, 0);
	endtask

	// A tag larger than the window; frames straddle the window edge.
	task automatic test_window();
		put_header(8'd4, 32'h0FFF_FFFF, 0);
		while (file_q.size() < WIN + 40)
			put_frame(1, pick_id(), 32'd30, 30);
		send_file(1, 0);
	endtask

	// Receiver holds off while a title stream keeps arriving.
	task automatic test_backpressure();
		hold_left = 300;
		put_header(8'd3, 32'd200, 0);
		repeat (5)
			put_frame(1, ID_TIT2, 32'd32, 32);
		send_file(1, 0);
	endtask

	// Mostly well-formed tags, plus broken tags and plain noise.
	task automatic test_random(input int count);
		int stop_at, sel;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			sel = $urandom_range(9);
			if (sel == 0) begin
				file_q.delete();
				repeat ($urandom_range(1, 20))
					file_q.push_back(8'($urandom_range(255)));
			end else if (sel == 1) begin
				build_tag(8'($urandom_range(255)), $urandom_range(0, 4), 1);
			end else begin
				build_tag(8'($urandom_range(2, 4)), $urandom_range(1, 5), 0);
			end
			send_file($urandom_range(9) != 0, ($urandom_range(4) == 0) ? 2 : 0);
		end
	endtask

	initial begin
		int waited;
		parser_clear();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_window();
		send_idle_pct = 14; recv_idle_pct = 50;
		test_random(500);
		send_idle_pct = 50; recv_idle_pct = 14;
		test_random(500);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_backpressure();
		test_random(500);
		@(negedge clk);
		in_valid = 1'b0;
		waited = 0;
		while (words_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (words_due.size() != 0) begin
			$display("simulation failed");
			$finish;
		end else begin
			repeat (10) @(posedge clk);
			if (!failed)
				$display("simulation ok");
			else
				$display("simulation failed");
			$finish;
		end
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule
